// ===== rtl/core/dns_answer_matcher_top_assert.svh =====
// Assertion macros shared by the matcher checker.
`ifndef DNS_ANSWER_MATCHER_TOP_ASSERT_SVH
`define DNS_ANSWER_MATCHER_TOP_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define DAM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DAM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dam_pkg.sv =====
// Types and constants shared by the DNS answer matcher modules.
package dam_pkg;

    // Input item kinds
    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    // Result kinds
    localparam logic [1:0] RK_ID    = 2'd0;
    localparam logic [1:0] RK_FULL  = 2'd1;
    localparam logic [1:0] RK_BYTE  = 2'd2;
    localparam logic [1:0] RK_EMPTY = 2'd3;

    // DNS layout constants
    localparam int unsigned HDR_LEN    = 12;
    localparam int unsigned MIN_LEN    = 14;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] TYPE_CNAME = 16'd5;
    localparam logic [7:0]  PTR_MARK   = 8'hc0;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [11:0] packet_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] transaction_id;
        logic [7:0]  answer_byte;
        logic        answer_last;
    } out_item_t;

    // Classified item between front and back
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [11:0] packet_length;
        logic        long_pkt;
    } dam_mid_t;

endpackage

// ===== rtl/core/dns_answer_matcher_top.sv =====
// Top level of the DNS answer matcher.
//
// Input queue: push an item while full is low; kind 0 asks for a new
// transaction ID, kind 1 carries one response byte with first_byte and
// packet_length. Result queue: while empty is low the oldest result sits
// on result; pop takes it. Each input causes zero or one result.
// Throughput is one item per cycle while the result queue has room: the
// parser handles a whole byte's worth of scan steps per item, capturing the
// header and record fields as they stream past, so no packet buffer is needed.
// An item is registered in the input queue, then the parser step writes
// its result into the result queue.
// When pop stays low the result queue fills, the parser halts, and then
// the input queue fills and raises full; nothing is dropped.
// Reset clears both queues, the pending table valid bits and the parser,
// and sets the next ID to 1. No clearing pass is needed.
module dns_answer_matcher_top
    import dam_pkg::*;
#(
    parameter int PENDING_DEPTH = 16,
    parameter int MAX_PACKET    = 2048,
    parameter int ADDR_MAX      = 1025
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    localparam int MID_W = $bits(dam_mid_t);
    localparam int OUT_W = $bits(out_item_t);

    logic      front_wr;
    dam_mid_t  front_data;
    dam_mid_t  mid_data;
    logic      mid_empty;
    logic      out_full;
    logic      go;
    logic      res_valid;
    out_item_t res;

    dam_front u_front (
        .push    (push),
        .item    (item),
        .wr_en   (front_wr),
        .wr_data (front_data)
    );

    dam_fifo #(.W(MID_W), .DEPTH(4)) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_wr),
        .wr_data (front_data),
        .full    (full),
        .rd_en   (go),
        .rd_data (mid_data),
        .empty   (mid_empty)
    );

    // Parser steps when an item waits and the result queue has room
    assign go = !mid_empty && !out_full;

    dam_back #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .MAX_PACKET    (MAX_PACKET),
        .ADDR_MAX      (ADDR_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .in_data   (mid_data),
        .res_valid (res_valid),
        .res       (res)
    );

    dam_fifo #(.W(OUT_W), .DEPTH(2)) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ===== rtl/core/dam_fifo.sv =====
// Small register-based queue.
module dam_fifo
#(
    parameter int W     = 8,
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/dam_front.sv =====
// Front end: takes input transfers and classifies them for the parser.
module dam_front
    import dam_pkg::*;
(
    input  logic     push,
    input  in_item_t item,
    output logic     wr_en,
    output dam_mid_t wr_data
);

    // Tag packets long enough to parse
    always_comb
    begin
        wr_en                 = push;
        wr_data.kind          = item.kind;
        wr_data.data_byte     = item.data_byte;
        wr_data.first_byte    = item.first_byte;
        wr_data.packet_length = item.packet_length;
        wr_data.long_pkt      = (item.packet_length > 12'(MIN_LEN));
    end

endmodule

// ===== rtl/core/dam_back.sv =====
// Back end: ID table and streaming DNS response parser.
module dam_back
    import dam_pkg::*;
#(
    parameter int PENDING_DEPTH = 16,
    parameter int MAX_PACKET    = 2048,
    parameter int ADDR_MAX      = 1025
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  dam_mid_t  in_data,
    output logic      res_valid,
    output out_item_t res
);

    localparam int OFF_W  = $clog2(MAX_PACKET + 1);
    localparam int SLOT_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int REM_W  = $clog2(ADDR_MAX + 1);
    localparam int AW     = 18;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HEAD, PH_NAME, PH_QTYPE, PH_LOOP,
        PH_SKIP, PH_REC, PH_CNAME, PH_FOUND, PH_DATA
    } phase_t;

    logic [15:0]       next_id_reg, next_id_next;
    logic              valid_reg [PENDING_DEPTH];
    logic              valid_next [PENDING_DEPTH];
    logic [15:0]       pend_id_reg [PENDING_DEPTH];
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]  len_reg, len_next;
    phase_t            phase_reg, phase_next;
    logic [15:0]       tid_reg, tid_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [OFF_W-1:0]  p_reg, p_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [7:0]        prev_reg, prev_next;

    logic              id_wr;
    logic [SLOT_W-1:0] id_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              hit_found;
    logic [SLOT_W-1:0] hit_idx;
    logic [15:0]       hdr_tid;

    logic [OFF_W-1:0]  e_v, k_v, p_v;
    phase_t            ph_v;
    logic [AW-1:0]     kk, ee, pp, wd, pn;
    logic [15:0]       wd16;
    logic [7:0]        bt;

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < PENDING_DEPTH; i++)
        begin
            if (!free_found && !valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Lowest valid slot holding the packet ID
    assign hdr_tid = {bt, tid_reg[7:0]};
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = 0; i < PENDING_DEPTH; i++)
        begin
            if (!hit_found && valid_reg[i] && pend_id_reg[i] == tid_reg)
            begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(i);
            end
        end
    end

    // Packet context after a possible restart
    always_comb
    begin
        bt   = in_data.data_byte;
        wd16 = {prev_reg, bt};
        if (in_data.first_byte)
        begin
            if (AW'(in_data.packet_length) > AW'(MAX_PACKET))
            begin
                e_v = OFF_W'(MAX_PACKET);
            end
            else
            begin
                e_v = OFF_W'(in_data.packet_length);
            end
            k_v  = '0;
            p_v  = '0;
            ph_v = in_data.long_pkt ? PH_HEAD : PH_IDLE;
        end
        else
        begin
            e_v  = len_reg;
            k_v  = off_reg;
            p_v  = p_reg;
            ph_v = phase_reg;
        end
        kk = AW'(k_v);
        ee = AW'(e_v);
        pp = AW'(p_v);
        wd = AW'(wd16);
        pn = pp + AW'(HDR_LEN) + wd;
    end

    // Next-state logic for one item
    always_comb
    begin
        next_id_next = next_id_reg;
        valid_next   = valid_reg;
        off_next     = off_reg;
        len_next     = len_reg;
        phase_next   = phase_reg;
        tid_next     = tid_reg;
        slot_next    = slot_reg;
        p_next       = p_reg;
        rem_next     = rem_reg;
        prev_next    = prev_reg;
        id_wr        = 1'b0;
        id_idx       = free_idx;
        res_valid    = 1'b0;
        res          = '0;

        if (go)
        begin
            if (in_data.kind == KIND_REQ)
            begin
                // ID request
                res_valid          = 1'b1;
                res.transaction_id = next_id_reg;
                if (free_found)
                begin
                    res.result_kind      = RK_ID;
                    valid_next[free_idx] = 1'b1;
                    id_wr                = 1'b1;
                    next_id_next         = next_id_reg + 16'd1;
                end
                else
                begin
                    res.result_kind = RK_FULL;
                end
            end
            else
            begin
                if (in_data.first_byte)
                begin
                    len_next   = e_v;
                    off_next   = '0;
                    phase_next = ph_v;
                    p_next     = '0;
                    rem_next   = '0;
                end
                if (ph_v != PH_IDLE && kk < ee)
                begin
                    off_next  = k_v + 1'b1;
                    prev_next = bt;
                    case (ph_v)
                        PH_HEAD:
                        begin
                            if (kk == AW'(0))
                            begin
                                tid_next = {tid_reg[15:8], bt};
                            end
                            if (kk == AW'(1))
                            begin
                                tid_next = hdr_tid;
                            end
                            if (kk == AW'(5))
                            begin
                                if (wd16 != 16'd1 || !hit_found)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    slot_next  = hit_idx;
                                    p_next     = OFF_W'(HDR_LEN);
                                    phase_next = PH_NAME;
                                end
                            end
                        end
                        PH_NAME:
                        begin
                            if (kk == pp)
                            begin
                                if (bt == 8'd0)
                                begin
                                    phase_next = (pp + AW'(5) > ee) ? PH_IDLE : PH_QTYPE;
                                end
                                else if (pp + AW'(1) >= ee)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    p_next = p_v + 1'b1;
                                end
                            end
                        end
                        PH_QTYPE:
                        begin
                            if (kk == pp + AW'(2))
                            begin
                                if (wd16 == TYPE_A && pp + AW'(17) < ee)
                                begin
                                    p_next     = p_v + OFF_W'(5);
                                    phase_next = PH_LOOP;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        PH_LOOP, PH_SKIP:
                        begin
                            if (kk == pp)
                            begin
                                // pointer mark only counts on the first name byte
                                if (ph_v == PH_LOOP && bt == PTR_MARK)
                                begin
                                    phase_next = PH_REC;
                                end
                                else if (bt == 8'd0)
                                begin
                                    p_next     = p_v - 1'b1;
                                    phase_next = PH_REC;
                                end
                                else if (pp + AW'(13) >= ee)
                                begin
                                    phase_next = PH_REC;
                                end
                                else
                                begin
                                    p_next     = p_v + 1'b1;
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                        PH_REC:
                        begin
                            if (kk == pp + AW'(3))
                            begin
                                if (wd16 == TYPE_CNAME)
                                begin
                                    phase_next = PH_CNAME;
                                end
                                else if (wd16 == TYPE_A && pp + AW'(HDR_LEN) < ee)
                                begin
                                    phase_next = PH_FOUND;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        PH_CNAME:
                        begin
                            if (kk == pp + AW'(11))
                            begin
                                if (pn + AW'(HDR_LEN) < ee)
                                begin
                                    p_next     = OFF_W'(pn);
                                    phase_next = PH_LOOP;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        PH_FOUND:
                        begin
                            if (kk == pp + AW'(11))
                            begin
                                if (pn > ee)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    valid_next[slot_reg] = 1'b0;
                                    p_next = OFF_W'(pp + AW'(HDR_LEN));
                                    if (wd16 == 16'd0)
                                    begin
                                        res_valid          = 1'b1;
                                        res.result_kind    = RK_EMPTY;
                                        res.transaction_id = tid_reg;
                                        res.answer_last    = 1'b1;
                                        phase_next         = PH_IDLE;
                                    end
                                    else
                                    begin
                                        if (wd > AW'(ADDR_MAX))
                                        begin
                                            rem_next = REM_W'(ADDR_MAX);
                                        end
                                        else
                                        begin
                                            rem_next = REM_W'(wd);
                                        end
                                        phase_next = PH_DATA;
                                    end
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            if (rem_reg != '0)
                            begin
                                res_valid          = 1'b1;
                                res.result_kind    = RK_BYTE;
                                res.transaction_id = tid_reg;
                                res.answer_byte    = bt;
                                res.answer_last    = (rem_reg == REM_W'(1));
                                rem_next           = rem_reg - 1'b1;
                                if (rem_reg == REM_W'(1))
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg <= 16'd1;
            for (int i = 0; i < PENDING_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            off_reg   <= '0;
            len_reg   <= '0;
            phase_reg <= PH_IDLE;
            tid_reg   <= '0;
            slot_reg  <= '0;
            p_reg     <= '0;
            rem_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            next_id_reg <= next_id_next;
            valid_reg   <= valid_next;
            off_reg     <= off_next;
            len_reg     <= len_next;
            phase_reg   <= phase_next;
            tid_reg     <= tid_next;
            slot_reg    <= slot_next;
            p_reg       <= p_next;
            rem_reg     <= rem_next;
            prev_reg    <= prev_next;
        end
    end

    // Pending ID storage
    always_ff @(posedge clk)
    begin
        if (id_wr)
        begin
            pend_id_reg[id_idx] <= next_id_reg;
        end
    end

endmodule

// ===== rtl/core/dam_checker.sv =====
// Port-level checks for the DNS answer matcher, with bind.
`include "dns_answer_matcher_top_assert.svh"

module dam_checker
    import dam_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pop,
    input logic      empty,
    input out_item_t result
);

    logic shown_other;
    logic last_ok;

    // A non-byte result is on the ports
    assign shown_other = !empty && result.result_kind != RK_BYTE;
    assign last_ok     = result.answer_last == (result.result_kind == RK_EMPTY);

    // No result is shown once reset has been seen
    `DAM_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> empty, "result shown during reset")

    // A waiting result holds until taken
    `DAM_ASSERT(a_hold, clk, rst_n, !empty && !pop |=> !empty && $stable(result), "result moved")

    // Only answer bytes carry data
    `DAM_ASSERT(a_byte_zero, clk, rst_n, shown_other |-> result.answer_byte == 8'd0, "stray data")

    // Last flag: set on empty answers, never on ID or table-full results
    `DAM_ASSERT(a_last, clk, rst_n, shown_other |-> last_ok, "bad last flag")

endmodule

bind dns_answer_matcher_top dam_checker u_dam_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

// ===== tb/dns_answer_matcher_top_tb.sv =====
// Self-checking testbench for the DNS answer matcher: ID issue and response parsing.
module dns_answer_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dam_pkg::*;

    typedef logic [7:0] octet_t;

    // Parser phases of the predictor
    typedef enum int unsigned {
        SCAN_IDLE, SCAN_HEAD, SCAN_NAME, SCAN_QTYPE, SCAN_LOOP,
        SCAN_SKIP, SCAN_REC, SCAN_FOUND, SCAN_DATA
    } scan_phase_t;

    localparam int unsigned TABLE_SLOTS = 16;
    localparam int unsigned PKT_CAP     = 2048;
    localparam int unsigned DATA_CLAMP  = 1025;

    // Predicts the answer stream and checks what the block delivers
    class dam_scoreboard;
        out_item_t   answers_due[$];
        int          errors;
        logic [15:0] next_tid;
        bit          slot_busy[TABLE_SLOTS];
        logic [15:0] slot_tid[TABLE_SLOTS];
        int unsigned offset, pkt_size, anchor, remaining, hit_slot;
        scan_phase_t phase;
        logic [15:0] answer_tid;
        octet_t      pkt_mem[PKT_CAP];

        function new();
            next_tid   = 16'd1;
            errors     = 0;
            offset     = 0;
            pkt_size   = 0;
            anchor     = 0;
            remaining  = 0;
            hit_slot   = 0;
            phase      = SCAN_IDLE;
            answer_tid = '0;
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
            foreach (pkt_mem[i]) pkt_mem[i] = '0;
        endfunction

        task flag(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function int unsigned octet_at(int unsigned i);
            return i < PKT_CAP ? int'(pkt_mem[i]) : 0;
        endfunction

        function int unsigned word_at(int unsigned i);
            return (octet_at(i) << 8) | octet_at(i + 1);
        endfunction

        // Walk the scan as far as the bytes received so far allow; 1 = empty answer
        function bit walk_scan();
            int unsigned have, e, p, tid, rtype, dlen;
            bit hit;
            have = offset;
            e    = pkt_size;
            p    = anchor;
            forever begin
                case (phase)
                    SCAN_HEAD: begin
                        if (have < 6) begin anchor = p; return 0; end
                        if (word_at(4) != 1) begin phase = SCAN_IDLE; return 0; end
                        tid = octet_at(0) | (octet_at(1) << 8);
                        hit = 0;
                        for (int i = 0; i < TABLE_SLOTS; i++) begin
                            if (!hit && slot_busy[i] && slot_tid[i] == tid[15:0]) begin
                                hit = 1;
                                hit_slot = i;
                            end
                        end
                        if (!hit) begin phase = SCAN_IDLE; return 0; end
                        answer_tid = tid[15:0];
                        p = HDR_LEN;
                        phase = SCAN_NAME;
                    end
                    SCAN_NAME: begin
                        if (p >= e) phase = SCAN_QTYPE;
                        else if (p >= have) begin anchor = p; return 0; end
                        else if (octet_at(p) == 0) phase = SCAN_QTYPE;
                        else p++;
                    end
                    SCAN_QTYPE: begin
                        if (p + 5 > e) begin phase = SCAN_IDLE; return 0; end
                        if (have < p + 3) begin anchor = p; return 0; end
                        if (word_at(p + 1) != TYPE_A) begin phase = SCAN_IDLE; return 0; end
                        p += 5;
                        phase = SCAN_LOOP;
                    end
                    SCAN_LOOP: begin
                        if (!(p + 12 < e)) begin phase = SCAN_IDLE; return 0; end
                        if (have <= p) begin anchor = p; return 0; end
                        phase = (octet_at(p) != PTR_MARK) ? SCAN_SKIP : SCAN_REC;
                    end
                    SCAN_SKIP: begin
                        if (p + 12 >= e) begin p--; phase = SCAN_REC; end
                        else if (have <= p) begin anchor = p; return 0; end
                        else if (octet_at(p) == 0) begin p--; phase = SCAN_REC; end
                        else p++;
                    end
                    SCAN_REC: begin
                        if (have < p + 4) begin anchor = p; return 0; end
                        rtype = word_at(p + 2);
                        if (rtype == TYPE_CNAME) begin
                            if (have < p + 12) begin anchor = p; return 0; end
                            p += 12 + word_at(p + 10);
                            phase = SCAN_LOOP;
                        end else if (rtype == TYPE_A) begin
                            phase = SCAN_FOUND;
                        end else begin
                            phase = SCAN_IDLE;
                            return 0;
                        end
                    end
                    SCAN_FOUND: begin
                        if (!(p + 12 < e)) begin phase = SCAN_IDLE; return 0; end
                        if (have < p + 12) begin anchor = p; return 0; end
                        dlen = word_at(p + 10);
                        p += 12;
                        if (p + dlen > e) begin phase = SCAN_IDLE; return 0; end
                        slot_busy[hit_slot] = 1'b0;
                        anchor = p;
                        if (dlen == 0) begin phase = SCAN_IDLE; return 1; end
                        remaining = dlen > DATA_CLAMP ? DATA_CLAMP : dlen;
                        phase = SCAN_DATA;
                        return 0;
                    end
                    default: begin
                        anchor = p;
                        return 0;
                    end
                endcase
            end
        endfunction

        // Advance the prediction by one item; 1 when it yields a result
        function bit predict(in_item_t it, output out_item_t r);
            int unsigned k;
            r = '0;
            if (it.kind == KIND_REQ) begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (!slot_busy[i]) begin
                        slot_busy[i] = 1'b1;
                        slot_tid[i] = next_tid;
                        r.result_kind = RK_ID;
                        r.transaction_id = next_tid;
                        next_tid++;
                        return 1;
                    end
                end
                r.result_kind = RK_FULL;
                r.transaction_id = next_tid;
                return 1;
            end
            if (it.first_byte) begin
                pkt_size  = it.packet_length > PKT_CAP ? PKT_CAP : it.packet_length;
                offset    = 0;
                anchor    = 0;
                remaining = 0;
                phase     = pkt_size > MIN_LEN ? SCAN_HEAD : SCAN_IDLE;
            end
            if (phase == SCAN_IDLE || offset >= pkt_size) return 0;
            k = offset;
            pkt_mem[k] = it.data_byte;
            offset++;
            if (phase == SCAN_DATA) begin
                if (k != anchor || remaining == 0) return 0;
                remaining--;
                anchor++;
                r.result_kind = RK_BYTE;
                r.transaction_id = answer_tid;
                r.answer_byte = it.data_byte;
                r.answer_last = remaining == 0;
                if (remaining == 0) phase = SCAN_IDLE;
                return 1;
            end
            if (walk_scan()) begin
                r.result_kind = RK_EMPTY;
                r.transaction_id = answer_tid;
                r.answer_last = 1'b1;
                return 1;
            end
            return 0;
        endfunction

        function void note(in_item_t it);
            out_item_t r;
            if (predict(it, r)) answers_due.push_back(r);
        endfunction

        task check(out_item_t got);
            out_item_t want;
            if (answers_due.size() == 0) begin
                flag($sformatf("unexpected result %p", got));
                return;
            end
            want = answers_due.pop_front();
            if (got.result_kind !== want.result_kind)
                flag($sformatf("result_kind %0d, want %0d", got.result_kind,
                               want.result_kind));
            if (got.transaction_id !== want.transaction_id)
                flag($sformatf("transaction_id %0d, want %0d", got.transaction_id,
                               want.transaction_id));
            if (got.answer_byte !== want.answer_byte)
                flag($sformatf("answer_byte %0h, want %0h", got.answer_byte,
                               want.answer_byte));
            if (got.answer_last !== want.answer_last)
                flag($sformatf("answer_last %0b, want %0b", got.answer_last,
                               want.answer_last));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      pop = 1'b0;
    logic      empty;
    out_item_t result;

    dam_scoreboard sb = new();
    int sent_items = 0;
    int burst_left = 4;
    int cyc = 0;

    dns_answer_matcher_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    always #2 clk = ~clk;

    // Receiver stall pattern: steps through four characters of pop behaviour
    always @(negedge clk)
    begin
        cyc++;
        case ((cyc >> 8) % 4)
            0: pop = 1'b1;
            1: pop = ($urandom_range(0, 1) == 1);
            2: pop = (cyc % 3 == 0);
            default: pop = ((cyc % 32) > 20);
        endcase
    end

    // Result check on every pop transfer
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty) sb.check(result);
    end

    // One input transfer; bursts of random length with random gaps
    task automatic send(in_item_t it);
        @(negedge clk);
        push = 1'b1;
        item = it;
        do @(posedge clk); while (full);
        sb.note(it);
        sent_items++;
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge clk);
            push = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
    endtask

    task automatic send_request();
        in_item_t it;
        it = $urandom;
        it.kind = KIND_REQ;
        send(it);
    endtask

    // Stream a packet; requests may slip in between its bytes
    task automatic send_packet(octet_t q[$], int unsigned len, bit lead = 1'b1);
        in_item_t it;
        foreach (q[i]) begin
            if ($urandom_range(0, 49) == 0) send_request();
            it.kind = KIND_BYTE;
            it.data_byte = q[i];
            it.first_byte = lead && (i == 0);
            it.packet_length = len[11:0];
            send(it);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        wait (sb.answers_due.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // Pick a pending ID most of the time, otherwise a random one
    function automatic logic [15:0] pick_tid();
        logic [15:0] live[$];
        foreach (sb.slot_busy[i]) if (sb.slot_busy[i]) live.push_back(sb.slot_tid[i]);
        if (live.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Build a response with CNAME records ahead of one A record
    function automatic void build_answer(logic [15:0] tid, int ncname, int dlen,
                                         bit plain_name, output octet_t q[$]);
        int n;
        q = {};
        q.push_back(tid[7:0]);
        q.push_back(tid[15:8]);
        q.push_back($urandom);
        q.push_back($urandom);
        q.push_back(8'h00);
        q.push_back(8'h01);
        repeat (6) q.push_back($urandom);
        repeat ($urandom_range(1, 3)) begin
            n = $urandom_range(1, 5);
            q.push_back(n);
            repeat (n) q.push_back($urandom_range(1, 255));
        end
        q.push_back(8'h00);
        q = {q, 8'h00, 8'h01, 8'h00, 8'h01};
        repeat (ncname) begin
            n = $urandom_range(0, 6);
            q = {q, PTR_MARK, 8'h0c, 8'h00, 8'h05, 8'h00, 8'h01};
            repeat (4) q.push_back($urandom);
            q = {q, 8'h00, octet_t'(n)};
            repeat (n) q.push_back($urandom);
        end
        // an uncompressed owner name exercises the name skip path
        if (plain_name) q = {q, 8'h03, 8'h61, 8'h62, 8'h00};
        else q = {q, PTR_MARK, 8'h0c};
        q = {q, 8'h00, 8'h01, 8'h00, 8'h01};
        repeat (4) q.push_back($urandom);
        q.push_back(dlen[15:8]);
        q.push_back(dlen[7:0]);
        repeat (dlen) q.push_back($urandom);
    endfunction

    task automatic good_packet(int dlen, int ncname);
        octet_t q[$];
        int unsigned len;
        int v;
        build_answer(pick_tid(), ncname, dlen, $urandom_range(0, 4) == 0, q);
        len = q.size();
        v = $urandom_range(0, 11);
        case (v)
            0: len += $urandom_range(1, 20);
            1: repeat ($urandom_range(1, 8)) q.push_back($urandom);
            2: len = $urandom_range(15, len - 1);
            3: q[$urandom_range(0, q.size() - 1)] = $urandom;
            4: q = q[0:$urandom_range(0, q.size() - 1)];
            default: ;
        endcase
        send_packet(q, len);
    endtask

    task automatic noise_packet();
        octet_t q[$];
        repeat ($urandom_range(1, 24)) q.push_back($urandom);
        send_packet(q, $urandom_range(0, 4095), $urandom_range(0, 4) != 0);
    endtask

    initial
    begin
        octet_t q[$];
        int r;
        int iter;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: fill the table, then one rejected request
        repeat (17) send_request();
        // short packet, then edge lengths and field extremes
        build_answer(16'd1, 0, 4, 0, q);
        send_packet(q, 14);
        build_answer(16'd1, 0, 0, 0, q);
        send_packet(q, q.size());
        build_answer(16'd2, 1, 3, 0, q);
        send_packet(q, 12'hfff);
        build_answer(16'd3, 0, 2, 0, q);
        q[5] = 8'h02;
        send_packet(q, q.size());
        build_answer(16'd3, 0, 2, 0, q);
        q[q.size() - 15] = 8'hff;
        send_packet(q, q.size());
        send_request();
        drain();

        // Random mix of requests, responses and noise
        iter = 0;
        while (sent_items < 1800) begin
            iter++;
            r = $urandom_range(0, 99);
            if (iter == 40) begin
                build_answer(pick_tid(), 0, 1030, 0, q);
                send_packet(q, q.size());
            end else if (r < 30) begin
                send_request();
            end else if (r < 80) begin
                good_packet(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8),
                            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
            end else begin
                noise_packet();
            end
            if (iter % 150 == 75) drain();
        end

        @(negedge clk);
        push = 1'b0;
        wait (sb.answers_due.size() == 0);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("dns_answer_matcher_top_tb: done, clean");
        else
            $display("dns_answer_matcher_top_tb: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("dns_answer_matcher_top_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dam_pkg.sv
rtl/core/dam_fifo.sv
rtl/core/dam_front.sv
rtl/core/dam_back.sv
rtl/core/dns_answer_matcher_top.sv
rtl/core/dam_checker.sv
tb/dns_answer_matcher_top_tb.sv
